// File: hw/rtl/biou_pkg.sv
// Shared constants and types for the box intersection-over-union block.
`default_nettype none

package biou_pkg;

    // Coordinate and area widths.
    localparam int COORD_BITS = 16;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int UNI_BITS   = AREA_BITS + 1;
    localparam int REM_BITS   = AREA_BITS + 2;

    // Ratio format and divider layout.
    localparam int RATIO_FRAC     = 16;
    localparam int RATIO_BITS     = RATIO_FRAC + 1;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = RATIO_FRAC / BITS_PER_STAGE;
    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << RATIO_FRAC;

    // Threshold register.
    localparam int MIN_UNION_BITS = 32;
    localparam logic [MIN_UNION_BITS-1:0] MIN_UNION_RESET = MIN_UNION_BITS'(4294);

    // One item in flight through the divider stages.
    typedef struct packed {
        logic [RATIO_FRAC-1:0] quo;
        logic [REM_BITS-1:0]   rem;
        logic [UNI_BITS-1:0]   uni;
        logic                  degen;
        logic                  full;
    } t_div_item;

endpackage

`default_nettype wire

// File: hw/rtl/biou_box_if.sv
// Input channel carrying one pair of boxes.
`default_nettype none

interface biou_box_if
    import biou_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] a_left;
    logic [COORD_BITS-1:0] a_top;
    logic [COORD_BITS-1:0] a_right;
    logic [COORD_BITS-1:0] a_bottom;
    logic [COORD_BITS-1:0] b_left;
    logic [COORD_BITS-1:0] b_top;
    logic [COORD_BITS-1:0] b_right;
    logic [COORD_BITS-1:0] b_bottom;

    modport source (
        output valid, a_left, a_top, a_right, a_bottom,
        output b_left, b_top, b_right, b_bottom,
        input  ready
    );
    modport sink (
        input  valid, a_left, a_top, a_right, a_bottom,
        input  b_left, b_top, b_right, b_bottom,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/biou_iou_if.sv
// Output channel carrying one overlap ratio.
`default_nettype none

interface biou_iou_if
    import biou_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [RATIO_BITS-1:0] overlap_ratio;
    logic                  degenerate;

    modport source (output valid, overlap_ratio, degenerate, input ready);
    modport sink (input valid, overlap_ratio, degenerate, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/biou_cfg_if.sv
// Configuration write channel for the union threshold.
`default_nettype none

interface biou_cfg_if
    import biou_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [MIN_UNION_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/biou_prep.sv
// Front stages: extents, areas, union and the special-case flags.
`default_nettype none

module biou_prep
    import biou_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_vld,
    input  wire logic [COORD_BITS-1:0]     i_a_left,
    input  wire logic [COORD_BITS-1:0]     i_a_top,
    input  wire logic [COORD_BITS-1:0]     i_a_right,
    input  wire logic [COORD_BITS-1:0]     i_a_bottom,
    input  wire logic [COORD_BITS-1:0]     i_b_left,
    input  wire logic [COORD_BITS-1:0]     i_b_top,
    input  wire logic [COORD_BITS-1:0]     i_b_right,
    input  wire logic [COORD_BITS-1:0]     i_b_bottom,
    input  wire logic [MIN_UNION_BITS-1:0] i_min_union,
    output logic                           o_vld,
    output t_div_item                      o_item
);

    // Clamped difference: zero when the edges are inverted.
    function automatic logic [COORD_BITS-1:0] extent(
        input logic [COORD_BITS-1:0] lo,
        input logic [COORD_BITS-1:0] hi
    );
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

    logic                  r_s1_vld, n_s1_vld;
    logic [COORD_BITS-1:0] r_iw, r_ih, r_wa, r_ha, r_wb, r_hb;
    logic [COORD_BITS-1:0] n_iw, n_ih;
    logic                  r_s2_vld;
    logic [AREA_BITS-1:0]  r_inter, r_area_a, r_area_b;
    logic [UNI_BITS-1:0]   n_uni;
    t_div_item             r_s3_item, n_s3_item;
    logic                  r_s3_vld;

    // Stage one: overlap extents from the inner edges, and the extents of each box.
    always_comb begin
        n_s1_vld = i_vld;
        n_iw = extent((i_a_left > i_b_left) ? i_a_left : i_b_left,
                      (i_a_right < i_b_right) ? i_a_right : i_b_right);
        n_ih = extent((i_a_top > i_b_top) ? i_a_top : i_b_top,
                      (i_a_bottom < i_b_bottom) ? i_a_bottom : i_b_bottom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_iw <= n_iw;
            r_ih <= n_ih;
            r_wa <= extent(i_a_left, i_a_right);
            r_ha <= extent(i_a_top, i_a_bottom);
            r_wb <= extent(i_b_left, i_b_right);
            r_hb <= extent(i_b_top, i_b_bottom);
        end
    end

    // Stage two: one multiplier for each area.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (i_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inter  <= AREA_BITS'(r_iw) * AREA_BITS'(r_ih);
            r_area_a <= AREA_BITS'(r_wa) * AREA_BITS'(r_ha);
            r_area_b <= AREA_BITS'(r_wb) * AREA_BITS'(r_hb);
        end
    end

    // Stage three: union, threshold test and the equal-boxes case.
    // The intersection never exceeds either area, so the union cannot go negative.
    always_comb begin
        n_uni = {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
        n_s3_item.quo   = '0;
        n_s3_item.rem   = REM_BITS'(r_inter);
        n_s3_item.uni   = n_uni;
        n_s3_item.degen = (n_uni <= UNI_BITS'(i_min_union));
        n_s3_item.full  = ({1'b0, r_inter} >= n_uni);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_item <= n_s3_item;
        end
    end

    assign o_vld  = r_s3_vld;
    assign o_item = r_s3_item;

endmodule

`default_nettype wire

// File: hw/rtl/biou_div_stage.sv
// One divider stage: BITS_PER_STAGE restoring quotient steps and a register.
`default_nettype none

module biou_div_stage
    import biou_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_vld,
    input  wire t_div_item i_item,
    output logic           o_vld,
    output t_div_item      o_item
);

    logic      r_vld;
    t_div_item r_item, n_item;

    // Shift the remainder, subtract the union where it fits, record the bit.
    always_comb begin
        n_item = i_item;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            n_item.rem = n_item.rem << 1;
            n_item.quo = n_item.quo << 1;
            if (n_item.rem >= REM_BITS'(n_item.uni)) begin
                n_item.rem    = n_item.rem - REM_BITS'(n_item.uni);
                n_item.quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

// File: hw/rtl/box_intersection_over_union.sv
// Pipeline: 3 front stages, then 8 divider stages, from an accepted item to its result.
// Throughput: one item per cycle while the output is not stalled; the divider resolves two quotient bits per stage.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
// Reset (synchronous, active low) clears all stage valid bits and sets min_union to 4294.
// Threshold writes are always ready and apply to items that reach the third stage afterward.
`default_nettype none

module box_intersection_over_union
    import biou_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    biou_box_if.sink   i_box,
    biou_cfg_if.sink   i_cfg,
    biou_iou_if.source o_iou
);

    logic [MIN_UNION_BITS-1:0] r_min_union;
    logic                      w_adv;
    logic                      w_vld [DIV_STAGES+1];
    t_div_item                 w_div [DIV_STAGES+1];
    t_div_item                 w_last;

    // Threshold register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_union <= MIN_UNION_RESET;
        end else if (i_cfg.valid) begin
            r_min_union <= i_cfg.data;
        end
    end

    // The whole pipeline moves unless a finished item waits at the output.
    assign w_adv       = !w_vld[DIV_STAGES] || o_iou.ready;
    assign i_box.ready = w_adv;

    biou_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_vld       (i_box.valid),
        .i_a_left    (i_box.a_left),
        .i_a_top     (i_box.a_top),
        .i_a_right   (i_box.a_right),
        .i_a_bottom  (i_box.a_bottom),
        .i_b_left    (i_box.b_left),
        .i_b_top     (i_box.b_top),
        .i_b_right   (i_box.b_right),
        .i_b_bottom  (i_box.b_bottom),
        .i_min_union (r_min_union),
        .o_vld       (w_vld[0]),
        .o_item      (w_div[0])
    );

    // Divider chain.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        biou_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (w_vld[g]),
            .i_item  (w_div[g]),
            .o_vld   (w_vld[g+1]),
            .o_item  (w_div[g+1])
        );
    end

    // Result selection: small union gives zero, equal boxes give exactly one.
    assign w_last           = w_div[DIV_STAGES];
    assign o_iou.valid      = w_vld[DIV_STAGES];
    assign o_iou.degenerate = w_last.degen;
    assign o_iou.overlap_ratio = w_last.degen ? '0 :
                                 w_last.full  ? RATIO_ONE :
                                 {1'b0, w_last.quo};

`ifndef SYNTH
    // A waiting result must hold off new items.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iou.valid && !o_iou.ready |-> !i_box.ready)
        else $error("input accepted while the output is stalled");

    // A degenerate result carries a zero ratio.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iou.valid && o_iou.degenerate |-> o_iou.overlap_ratio == '0)
        else $error("degenerate item with nonzero ratio");

    // The ratio never exceeds one.
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iou.valid |-> o_iou.overlap_ratio <= RATIO_ONE)
        else $error("overlap ratio above one");

    // After the last step the remainder stays below the union.
    a_rem_below_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[DIV_STAGES] && !w_last.degen && !w_last.full
            |-> w_last.rem < REM_BITS'(w_last.uni))
        else $error("divider remainder not reduced");
`endif

endmodule

`default_nettype wire
